>>> hw/rtl/yrc_pkg.sv
// ----------------------------------------------------------------------------
// YUYV to RGB converter package
// Shared types, fixed-point constants and pipeline stage indexes.
// ----------------------------------------------------------------------------
package yrc_pkg;

  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned TERM_W   = 20;
  localparam int unsigned SUM_W    = TERM_W + 1;

  typedef logic        [SAMPLE_W-1:0] sample_t;
  typedef logic signed [TERM_W-1:0]   term_t;
  typedef logic signed [SUM_W-1:0]    sum_t;

  // Colour conversion gains, scaled by 1000.
  localparam term_t K_LUMA_GAIN    = term_t'(1164);
  localparam term_t K_RED_V_GAIN   = term_t'(1159);
  localparam term_t K_GREEN_U_GAIN = term_t'(380);
  localparam term_t K_GREEN_V_GAIN = term_t'(813);
  localparam term_t K_BLUE_U_GAIN  = term_t'(2018);
  localparam term_t K_CHROMA_MID   = term_t'(128);
  localparam term_t K_LUMA_BLACK   = term_t'(16);

  localparam int unsigned SCALE_DIV = 1000;
  localparam int unsigned CHAN_MAX  = 255;

  // Any sum at or above this value saturates to full scale.
  localparam int unsigned SAT_LIMIT = (CHAN_MAX + 1) * SCALE_DIV;

  // Divide by SCALE_DIV as a multiply by a rounded-up reciprocal. The error
  // term of this reciprocal stays below one LSB for every sum under
  // SAT_LIMIT, so the quotient is exact there.
  localparam int unsigned QUO_IN_W    = 18;
  localparam int unsigned RECIP_SHIFT = 28;
  localparam int unsigned RECIP_W     = 19;
  localparam int unsigned PROD_W      = QUO_IN_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + SCALE_DIV - 1) / SCALE_DIV);

  localparam sum_t     SAT_LIMIT_S = sum_t'(SAT_LIMIT);
  localparam sample_t  CHAN_FULL   = sample_t'(CHAN_MAX);
  localparam sample_t  CHAN_ZERO   = sample_t'(0);

  // Pipeline stages.
  localparam int unsigned NUM_STAGES = 4;
  localparam int unsigned ST_TERMS   = 0;
  localparam int unsigned ST_SUM     = 1;
  localparam int unsigned ST_PROD    = 2;
  localparam int unsigned ST_OUT     = 3;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } pipe_ctrl_t;

  typedef struct packed {
    sample_t luma_first;
    sample_t chroma_blue;
    sample_t luma_second;
    sample_t chroma_red;
    logic    frame_last;
  } yuyv_word_t;

  typedef struct packed {
    sample_t red_first;
    sample_t green_first;
    sample_t blue_first;
    sample_t red_second;
    sample_t green_second;
    sample_t blue_second;
    logic    frame_last_out;
  } rgb_word_t;

endpackage

>>> hw/rtl/yrc_yuyv_if.sv
// ----------------------------------------------------------------------------
// YUYV input stream interface
// Valid/ready channel carrying one packed macropixel word.
// ----------------------------------------------------------------------------
interface yrc_yuyv_if;
  import yrc_pkg::*;

  logic       valid;
  logic       ready;
  yuyv_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/yrc_rgb_if.sv
// ----------------------------------------------------------------------------
// RGB output stream interface
// Valid/ready channel carrying one pair of RGB24 pixels.
// ----------------------------------------------------------------------------
interface yrc_rgb_if;
  import yrc_pkg::*;

  logic      valid;
  logic      ready;
  rgb_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/yrc_ctrl.sv
// ----------------------------------------------------------------------------
// YUYV to RGB pipeline control
// Per-stage valid bits and load enables for the stallable pipeline.
// ----------------------------------------------------------------------------
module yrc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output yrc_pkg::pipe_ctrl_t ctrl_o
);
  import yrc_pkg::*;

  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] valid_d;
  logic [NUM_STAGES-1:0] en;
  logic [NUM_STAGES-1:0] upstream;

  // A stage may take a new word when it is empty or when its word moves on.
  always_comb begin
    en[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || out_ready_i;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !valid_q[i] || en[i+1];
    end
  end

  assign upstream    = {valid_q[NUM_STAGES-2:0], in_valid_i};
  assign valid_d     = (en & upstream) | (~en & valid_q);
  assign ctrl_o.load = en & upstream;
  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[NUM_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Words in flight change only by the words accepted and delivered.
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |->
      $countones(valid_q) == $countones($past(valid_q))
                             + int'($past(in_valid_i && in_ready_o))
                             - int'($past(out_valid_o && out_ready_i)))
    else $error("pipeline occupancy mismatch");

  // Any bubble in the pipeline lets the input side advance.
  a_bubble_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(&valid_q) |-> in_ready_o)
    else $error("input stalled although the pipeline has a bubble");

  // A middle-stage word blocked by its successor stays in place.
  a_sum_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[ST_SUM] && !en[ST_PROD]) |=> valid_q[ST_SUM])
    else $error("stalled word lost in the sum stage");

endmodule

>>> hw/rtl/yrc_terms.sv
// ----------------------------------------------------------------------------
// YUYV to RGB term stage
// Forms the two scaled luma terms and the three shared chroma terms.
// ----------------------------------------------------------------------------
module yrc_terms (
  input  logic                clk_i,
  input  logic                load_i,
  input  yrc_pkg::yuyv_word_t word_i,
  output yrc_pkg::term_t      luma_first_o,
  output yrc_pkg::term_t      luma_second_o,
  output yrc_pkg::term_t      red_o,
  output yrc_pkg::term_t      green_o,
  output yrc_pkg::term_t      blue_o
);
  import yrc_pkg::*;

  term_t cu;
  term_t cv;
  term_t luma_first_d, luma_second_d, red_d, green_d, blue_d;
  term_t luma_first_q, luma_second_q, red_q, green_q, blue_q;

  // Chroma samples are offset binary around mid scale.
  always_comb begin
    cu            = term_t'({1'b0, word_i.chroma_blue}) - K_CHROMA_MID;
    cv            = term_t'({1'b0, word_i.chroma_red}) - K_CHROMA_MID;
    luma_first_d  = (term_t'({1'b0, word_i.luma_first}) - K_LUMA_BLACK) * K_LUMA_GAIN;
    luma_second_d = (term_t'({1'b0, word_i.luma_second}) - K_LUMA_BLACK) * K_LUMA_GAIN;
    red_d         = cv * K_RED_V_GAIN;
    green_d       = -(cu * K_GREEN_U_GAIN) - (cv * K_GREEN_V_GAIN);
    blue_d        = cu * K_BLUE_U_GAIN;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      luma_first_q  <= luma_first_d;
      luma_second_q <= luma_second_d;
      red_q         <= red_d;
      green_q       <= green_d;
      blue_q        <= blue_d;
    end
  end

  assign luma_first_o  = luma_first_q;
  assign luma_second_o = luma_second_q;
  assign red_o         = red_q;
  assign green_o       = green_q;
  assign blue_o        = blue_q;

endmodule

>>> hw/rtl/yrc_scale.sv
// ----------------------------------------------------------------------------
// YUYV to RGB channel scaler
// Adds luma and chroma terms, divides by the scale and clamps to 8 bits.
// ----------------------------------------------------------------------------
module yrc_scale (
  input  logic                clk_i,
  input  yrc_pkg::pipe_ctrl_t ctrl_i,
  input  yrc_pkg::term_t      luma_i,
  input  yrc_pkg::term_t      chroma_i,
  output yrc_pkg::sample_t    chan_o
);
  import yrc_pkg::*;

  sum_t               sum_d, sum_q;
  logic               neg_d, neg_q;
  logic               over_d, over_q;
  logic [PROD_W-1:0]  prod;
  sample_t            quo_d, quo_q;
  sample_t            chan_d, chan_q;

  assign sum_d = sum_t'(luma_i) + sum_t'(chroma_i);

  // A negative sum truncates to zero or below, so it clamps to zero.
  // In range, the reciprocal multiply gives the exact quotient.
  always_comb begin
    neg_d  = sum_q[SUM_W-1];
    over_d = !neg_d && (sum_q >= SAT_LIMIT_S);
    prod   = PROD_W'(sum_q[QUO_IN_W-1:0]) * PROD_W'(RECIP);
    quo_d  = prod[RECIP_SHIFT +: SAMPLE_W];
  end

  always_comb begin
    priority if (neg_q) begin
      chan_d = CHAN_ZERO;
    end else if (over_q) begin
      chan_d = CHAN_FULL;
    end else begin
      chan_d = quo_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[ST_SUM]) begin
      sum_q <= sum_d;
    end
    if (ctrl_i.load[ST_PROD]) begin
      neg_q  <= neg_d;
      over_q <= over_d;
      quo_q  <= quo_d;
    end
    if (ctrl_i.load[ST_OUT]) begin
      chan_q <= chan_d;
    end
  end

  assign chan_o = chan_q;

endmodule

>>> hw/rtl/yuyv_to_rgb_converter_core.sv
// ----------------------------------------------------------------------------
// YUYV to RGB converter core
// Converts packed YUV 4:2:2 macropixels into pairs of clamped RGB24 pixels.
// ----------------------------------------------------------------------------
// Usage:
// Each word on the yuyv_i channel is one macropixel: two luma samples that
// share one blue and one red chroma sample, plus an end-of-frame flag. For
// each accepted word the rgb_o channel delivers exactly one word holding the
// two RGB pixels and a copy of the flag, in the same order.
// The datapath is four register stages: chroma and luma terms, channel sums,
// reciprocal multiply for the divide by 1000, and the clamped output
// register. A word accepted on yuyv_i passes through these registers in order
// and is offered on rgb_o from the output register. Throughput is one word
// per cycle while rgb_o.ready is high; each stage holds one word and moves it
// on whenever the next stage is free, so bubbles close up automatically.
// When the receiver holds rgb_o.ready low, the output stage keeps its word
// and the stages behind it fill up; yuyv_i.ready drops only once all four
// stages hold a word. No word is lost or repeated across a stall.
// Reset clears the stage valid bits only, so the block comes out of reset
// empty and ready; the data registers are not reset.
// ----------------------------------------------------------------------------
module yuyv_to_rgb_converter_core (
  input  logic    clk_i,
  input  logic    rst_ni,
  yrc_yuyv_if.sink  yuyv_i,
  yrc_rgb_if.source rgb_o
);
  import yrc_pkg::*;

  pipe_ctrl_t            ctrl;
  term_t                 luma_first, luma_second;
  term_t                 red_term, green_term, blue_term;
  sample_t               red_first, green_first, blue_first;
  sample_t               red_second, green_second, blue_second;
  logic [NUM_STAGES-1:0] last_q;
  logic [NUM_STAGES-1:0] last_d;

  // Valid bits and stage enables for the whole datapath.
  yrc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (yuyv_i.valid),
    .in_ready_o  (yuyv_i.ready),
    .out_valid_o (rgb_o.valid),
    .out_ready_i (rgb_o.ready),
    .ctrl_o      (ctrl)
  );

  // Stage one: the chroma terms are formed once and shared by both pixels.
  yrc_terms u_terms (
    .clk_i         (clk_i),
    .load_i        (ctrl.load[ST_TERMS]),
    .word_i        (yuyv_i.data),
    .luma_first_o  (luma_first),
    .luma_second_o (luma_second),
    .red_o         (red_term),
    .green_o       (green_term),
    .blue_o        (blue_term)
  );

  // Stages two to four: one scaler for each of the six output channels.
  yrc_scale u_red_first (
    .clk_i (clk_i), .ctrl_i (ctrl), .luma_i (luma_first),
    .chroma_i (red_term), .chan_o (red_first)
  );
  yrc_scale u_green_first (
    .clk_i (clk_i), .ctrl_i (ctrl), .luma_i (luma_first),
    .chroma_i (green_term), .chan_o (green_first)
  );
  yrc_scale u_blue_first (
    .clk_i (clk_i), .ctrl_i (ctrl), .luma_i (luma_first),
    .chroma_i (blue_term), .chan_o (blue_first)
  );
  yrc_scale u_red_second (
    .clk_i (clk_i), .ctrl_i (ctrl), .luma_i (luma_second),
    .chroma_i (red_term), .chan_o (red_second)
  );
  yrc_scale u_green_second (
    .clk_i (clk_i), .ctrl_i (ctrl), .luma_i (luma_second),
    .chroma_i (green_term), .chan_o (green_second)
  );
  yrc_scale u_blue_second (
    .clk_i (clk_i), .ctrl_i (ctrl), .luma_i (luma_second),
    .chroma_i (blue_term), .chan_o (blue_second)
  );

  // The end-of-frame flag rides along with its word through every stage.
  assign last_d = {last_q[NUM_STAGES-2:0], yuyv_i.data.frame_last};

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_STAGES; i++) begin
      if (ctrl.load[i]) begin
        last_q[i] <= last_d[i];
      end
    end
  end

  always_comb begin
    rgb_o.data.red_first      = red_first;
    rgb_o.data.green_first    = green_first;
    rgb_o.data.blue_first     = blue_first;
    rgb_o.data.red_second     = red_second;
    rgb_o.data.green_second   = green_second;
    rgb_o.data.blue_second    = blue_second;
    rgb_o.data.frame_last_out = last_q[ST_OUT];
  end

endmodule
